>>> src/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
// used by the header memory, the controller, the top level and its checker

package ffha_pkg;

  localparam int unsigned HeapBytesDef = 32768;
  localparam int unsigned HdrBytes     = 4;
  localparam logic [15:0] EndMark      = 16'hFFFF;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;

  // one header: size in the upper half, next offset in the lower half
  typedef struct packed {
    logic [15:0] size;
    logic [15:0] next;
  } hdr_t;

  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic [15:0] wr_addr;
    hdr_t        wr_data;
  } mem_req_t;

endpackage

>>> src/ffha_hdr_mem.sv
// header store: one synchronous memory entry per heap byte offset
// depends on ffha_pkg; offsets outside the heap read as zero and drop writes

module ffha_hdr_mem import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HeapBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output hdr_t     rd_data_o
);

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam logic [16:0] Depth = 17'(HEAP_BYTES);

  hdr_t mem_q [HEAP_BYTES];
  hdr_t rd_q;
  logic oob_q;
  logic use_init_q;
  logic init0_q;
  logic wr_in;
  logic rd_in;

  assign wr_in = ({1'b0, req_i.wr_addr} < Depth);
  assign rd_in = ({1'b0, req_i.rd_addr} < Depth);

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_in) begin
      mem_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr[AW-1:0]];
    end
  end

  // entry 0 holds the whole heap until it is first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q    <= 1'b0;
      oob_q      <= 1'b0;
      use_init_q <= 1'b0;
    end else begin
      if (req_i.wr_en && req_i.wr_addr == 16'd0) begin
        init0_q <= 1'b1;
      end
      if (req_i.rd_en) begin
        oob_q      <= !rd_in;
        use_init_q <= (req_i.rd_addr == 16'd0) && !init0_q;
      end
    end
  end

  always_comb begin
    if (oob_q) begin
      rd_data_o = '0;
    end else if (use_init_q) begin
      rd_data_o.size = 16'(HEAP_BYTES - HdrBytes);
      rd_data_o.next = EndMark;
    end else begin
      rd_data_o = rd_q;
    end
  end

endmodule

>>> src/ffha_ctrl.sv
// list-walk sequencer: read, modify and write back headers, at most one access a cycle
// depends on ffha_pkg; drives the header memory and holds the result register

module ffha_ctrl import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HeapBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [15:0]         request_size_i,
  input  logic [15:0]         free_offset_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic [15:0]         data_offset_o,
  output mem_req_t            mem_req_o,
  input  hdr_t                rd_data_i
);

  localparam logic [15:0] Heap16   = 16'(HEAP_BYTES);
  localparam logic [17:0] Heap18   = 18'(HEAP_BYTES);
  localparam logic [15:0] MaxBlk   = 16'(HEAP_BYTES - HdrBytes);
  localparam logic [15:0] Hdr16    = 16'(HdrBytes);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ALOOK = 5'd1;
  localparam logic [4:0] S_ACHK  = 5'd2;
  localparam logic [4:0] S_ASPL  = 5'd3;
  localparam logic [4:0] S_AWCUR = 5'd4;
  localparam logic [4:0] S_ARPRV = 5'd5;
  localparam logic [4:0] S_AWPRV = 5'd6;
  localparam logic [4:0] S_FSTRT = 5'd7;
  localparam logic [4:0] S_FCHK  = 5'd8;
  localparam logic [4:0] S_FLOOK = 5'd9;
  localparam logic [4:0] S_FWCHK = 5'd10;
  localparam logic [4:0] S_FW1   = 5'd11;
  localparam logic [4:0] S_FW2   = 5'd12;
  localparam logic [4:0] S_FJ1A  = 5'd13;
  localparam logic [4:0] S_FJ1B  = 5'd14;
  localparam logic [4:0] S_JRD   = 5'd15;
  localparam logic [4:0] S_JCHK  = 5'd16;
  localparam logic [4:0] S_JWA   = 5'd17;
  localparam logic [4:0] S_JWB   = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0]  state_q, state_d;
  logic [15:0] head_q, head_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] prev_q, prev_d;
  logic        has_prev_q, has_prev_d;
  logic [15:0] steps_q, steps_d;
  logic [15:0] want_q, want_d;
  logic [15:0] blk_q, blk_d;
  logic [15:0] bsz_q, bsz_d;
  logic [15:0] link_q, link_d;
  logic [15:0] csz_q, csz_d;
  logic [15:0] tnext_q, tnext_d;
  logic [15:0] tsize_q, tsize_d;
  logic        rok_q, rok_d;
  logic [15:0] roff_q, roff_d;
  logic        ovalid_q, ovalid_d;
  logic        ook_q, ook_d;
  logic [15:0] ooff_q, ooff_d;
  logic [17:0] split18;
  logic [17:0] cur_end18;
  logic [17:0] blk_end18;
  logic [16:0] want_p4;

  assign split18   = {2'b0, cur_q} + 18'(HdrBytes) + {2'b0, want_q};
  assign cur_end18 = {2'b0, cur_q} + 18'(HdrBytes) + {2'b0, bsz_q};
  assign blk_end18 = {2'b0, blk_q} + 18'(HdrBytes) + {2'b0, rd_data_i.size};
  assign want_p4   = {1'b0, want_q} + 17'(HdrBytes);

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ovalid_q;
  assign ok_o          = ook_q;
  assign data_offset_o = ooff_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    has_prev_d = has_prev_q;
    steps_d    = steps_q;
    want_d     = want_q;
    blk_d      = blk_q;
    bsz_d      = bsz_q;
    link_d     = link_q;
    csz_d      = csz_q;
    tnext_d    = tnext_q;
    tsize_d    = tsize_q;
    rok_d      = rok_q;
    roff_d     = roff_q;
    ovalid_d   = ovalid_q;
    ook_d      = ook_q;
    ooff_d     = ooff_q;
    mem_req_o  = '0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        rok_d  = 1'b0;
        roff_d = EndMark;
        if (in_valid_i) begin
          want_d     = request_size_i;
          cur_d      = head_q;
          steps_d    = '0;
          has_prev_d = 1'b0;
          if (opcode_i == OpAlloc) begin
            state_d = (request_size_i == 16'd0) ? S_DONE : S_ALOOK;
          end else if (free_offset_i < Hdr16 || free_offset_i == EndMark) begin
            state_d = S_DONE;
          end else begin
            blk_d   = free_offset_i - Hdr16;
            state_d = S_FSTRT;
          end
        end
      end
      S_ALOOK: begin
        if (cur_q == EndMark) begin
          state_d = S_DONE;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = cur_q;
          state_d           = S_ACHK;
        end
      end
      S_ACHK: begin
        if (rd_data_i.size < want_q) begin
          if (steps_q >= Heap16) begin
            state_d = S_DONE;
          end else begin
            steps_d    = steps_q + 16'd1;
            prev_d     = cur_q;
            has_prev_d = 1'b1;
            cur_d      = rd_data_i.next;
            state_d    = S_ALOOK;
          end
        end else begin
          link_d  = rd_data_i.next;
          csz_d   = rd_data_i.size;
          state_d = ({1'b0, rd_data_i.size} > want_p4) ? S_ASPL : S_AWCUR;
        end
      end
      S_ASPL: begin
        mem_req_o.wr_en        = (split18 < Heap18);
        mem_req_o.wr_addr      = split18[15:0];
        mem_req_o.wr_data.next = link_q;
        mem_req_o.wr_data.size = csz_q - want_q - Hdr16;
        link_d  = split18[15:0];
        csz_d   = want_q;
        state_d = S_AWCUR;
      end
      S_AWCUR: begin
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = cur_q;
        mem_req_o.wr_data.next = EndMark;
        mem_req_o.wr_data.size = csz_q;
        rok_d  = 1'b1;
        roff_d = cur_q + Hdr16;
        if (has_prev_q) begin
          state_d = S_ARPRV;
        end else begin
          head_d  = link_q;
          state_d = S_DONE;
        end
      end
      S_ARPRV: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = prev_q;
        state_d           = S_AWPRV;
      end
      S_AWPRV: begin
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = prev_q;
        mem_req_o.wr_data.next = link_q;
        mem_req_o.wr_data.size = rd_data_i.size;
        state_d                = S_DONE;
      end
      S_FSTRT: begin
        if (blk_q > MaxBlk) begin
          state_d = S_DONE;
        end else begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = blk_q;
          state_d           = S_FCHK;
        end
      end
      S_FCHK: begin
        if (rd_data_i.next != EndMark) begin
          state_d = S_DONE;
        end else begin
          tsize_d = rd_data_i.size;
          if (head_q > blk_q) begin
            mem_req_o.wr_en        = 1'b1;
            mem_req_o.wr_addr      = blk_q;
            mem_req_o.wr_data.next = head_q;
            mem_req_o.wr_data.size = rd_data_i.size;
            head_d  = blk_q;
            state_d = S_JRD;
          end else begin
            cur_d   = head_q;
            steps_d = '0;
            state_d = S_FLOOK;
          end
        end
      end
      S_FLOOK: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = cur_q;
        state_d           = S_FWCHK;
      end
      S_FWCHK: begin
        if (rd_data_i.next < blk_q && steps_q < Heap16) begin
          cur_d   = rd_data_i.next;
          steps_d = steps_q + 16'd1;
          state_d = S_FLOOK;
        end else begin
          link_d  = rd_data_i.next;
          bsz_d   = rd_data_i.size;
          state_d = S_FW1;
        end
      end
      S_FW1: begin
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = blk_q;
        mem_req_o.wr_data.next = link_q;
        mem_req_o.wr_data.size = tsize_q;
        state_d                = S_FW2;
      end
      S_FW2: begin
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = cur_q;
        mem_req_o.wr_data.next = blk_q;
        mem_req_o.wr_data.size = bsz_q;
        state_d = (cur_end18 == {2'b0, blk_q}) ? S_FJ1A : S_JRD;
      end
      S_FJ1A: begin
        // lower neighbor absorbs the freed block
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = cur_q;
        mem_req_o.wr_data.next = link_q;
        mem_req_o.wr_data.size = bsz_q + Hdr16 + tsize_q;
        state_d                = S_FJ1B;
      end
      S_FJ1B: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = blk_q;
        blk_d             = cur_q;
        state_d           = S_JRD;
      end
      S_JRD: begin
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = blk_q;
        state_d           = S_JCHK;
      end
      S_JCHK: begin
        rok_d = 1'b1;
        if (blk_end18 == {2'b0, rd_data_i.next}) begin
          tnext_d           = rd_data_i.next;
          tsize_d           = rd_data_i.size;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = rd_data_i.next;
          state_d           = S_JWA;
        end else begin
          state_d = S_DONE;
        end
      end
      S_JWA: begin
        // block absorbs its upper neighbor
        mem_req_o.wr_en        = 1'b1;
        mem_req_o.wr_addr      = blk_q;
        mem_req_o.wr_data.next = rd_data_i.next;
        mem_req_o.wr_data.size = tsize_q + Hdr16 + rd_data_i.size;
        state_d                = S_JWB;
      end
      S_JWB: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = tnext_q;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ook_d    = rok_q;
          ooff_d   = roff_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      ovalid_q   <= 1'b0;
      has_prev_q <= 1'b0;
      steps_q    <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      ovalid_q   <= ovalid_d;
      has_prev_q <= has_prev_d;
      steps_q    <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    want_q  <= want_d;
    blk_q   <= blk_d;
    bsz_q   <= bsz_d;
    link_q  <= link_d;
    csz_q   <= csz_d;
    tnext_q <= tnext_d;
    tsize_q <= tsize_d;
    rok_q   <= rok_d;
    roff_q  <= roff_d;
    ook_q   <= ook_d;
    ooff_q  <= ooff_d;
  end

endmodule

>>> src/first_fit_heap_allocator.sv
// first-fit heap allocator: address-ordered free list with coalescing
// depends on ffha_pkg, ffha_hdr_mem and ffha_ctrl
//
// usage:
//   s_axis carries one request per transaction: tuser opcode 0 allocates
//   request_size bytes, opcode 1 frees the block at free_offset.
//   m_axis returns one result per request: ok in tuser and the data offset
//   (0xFFFF on failure and for every free).
// timing:
//   one request is in work at a time; the sequencer does at most one header
//   memory access per cycle, and header reads are registered.
//   the list walk through the header memory sets the rate.
// reset:
//   the heap becomes one free block at offset 0; no clearing pass.
// stalls:
//   a finished result waits in the output register; the next request is
//   taken meanwhile and its result waits until the register drains.

module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES = HeapBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] request_size, [31:16] free_offset
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] data_offset
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] ok
  output logic                m_axis_tuser
);

  mem_req_t    mem_req;
  hdr_t        rd_data;

  ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .request_size_i (s_axis_tdata[15:0]),
    .free_offset_i  (s_axis_tdata[31:16]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .ok_o           (m_axis_tuser),
    .data_offset_o  (m_axis_tdata),
    .mem_req_o      (mem_req),
    .rd_data_i      (rd_data)
  );

  ffha_hdr_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

>>> src/ffha_checker.sv
// port-level checks of the first-fit heap allocator
// depends on ffha_pkg; attached to the top level by the bind below

module ffha_checker import ffha_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  // a failed or ignored request reports the end marker
  a_fail_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == EndMark)
    else $error("failed result without end marker");

  // an allocated data area always lies past its header
  a_off_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && m_axis_tdata != EndMark
    |-> m_axis_tdata >= 16'(HdrBytes))
    else $error("data offset inside first header");

  // a taken request drops s_axis_tready, so no second request is taken while one is in work
  a_no_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
